// File: hw/rtl/periodic_value_noise_sampler_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the periodic value noise sampler
// Shared property templates, clocked on clk and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef PERIODIC_VALUE_NOISE_SAMPLER_ASSERT_SVH
`define PERIODIC_VALUE_NOISE_SAMPLER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PVNS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PVNS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/pvns_pkg.sv
// ---------------------------------------------------------------------------
// pvns_pkg
// Types, constants and helper functions of the periodic value noise sampler.
// ---------------------------------------------------------------------------
package pvns_pkg;

  // Lattice geometry.
  localparam int MAX_SIDE   = 64;
  localparam int SIDE_W     = 7;
  localparam int COORD_W    = 6;
  localparam int IDX_W      = 12;
  localparam int DEPTH      = MAX_SIDE * MAX_SIDE;
  localparam int VAL_W      = 16;

  // Fixed-point format: 16 fraction bits.
  localparam int FRAC_W     = 16;
  localparam int SCALE      = 65536;
  localparam int HALF       = SCALE / 2;
  localparam int FADE_W     = FRAC_W + 1;

  // Pipeline depth.
  localparam int NUM_STAGES = 13;
  localparam int MEM_STAGE  = 9;

  // Request kinds carried on tuser.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  // Lattice write port.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [VAL_W-1:0] data;
  } lat_wr_t;

  // Everything one request carries down the pipeline.
  typedef struct packed {
    logic                     op;
    logic [IDX_W-1:0]         widx;
    logic [VAL_W-1:0]         wval;
    logic                     xneg;
    logic                     yneg;
    logic [FRAC_W-1:0]        xmag;
    logic [FRAC_W-1:0]        ymag;
    logic [SIDE_W-1:0]        xrem;
    logic [SIDE_W-1:0]        yrem;
    logic [FRAC_W-1:0]        xf;
    logic [FRAC_W-1:0]        yf;
    logic [31:0]              xsq;
    logic [31:0]              ysq;
    logic [16:0]              xt2;
    logic [16:0]              yt2;
    logic [32:0]              xcube;
    logic [32:0]              ycube;
    logic [20:0]              xpoly;
    logic [20:0]              ypoly;
    logic [16:0]              xt3;
    logic [16:0]              yt3;
    logic [37:0]              xfp;
    logic [37:0]              yfp;
    logic [FADE_W-1:0]        fx;
    logic [FADE_W-1:0]        fy;
    logic [COORD_W-1:0]       wx;
    logic [COORD_W-1:0]       wy;
    logic [COORD_W-1:0]       wx1;
    logic [COORD_W-1:0]       wy1;
    logic [IDX_W-1:0]         row0;
    logic [IDX_W-1:0]         idx_a;
    logic [IDX_W-1:0]         idx_b;
    logic [IDX_W-1:0]         idx_c;
    logic [IDX_W-1:0]         idx_d;
    logic [VAL_W-1:0]         lo_base;
    logic [VAL_W-1:0]         hi_base;
    logic signed [34:0]       plo;
    logic signed [34:0]       phi;
    logic signed [17:0]       lo;
    logic signed [17:0]       hi;
    logic signed [35:0]       pv;
    logic [VAL_W-1:0]         noise;
  } stage_t;

  // Four steps of a restoring remainder: shift in four dividend bits.
  function automatic logic [SIDE_W-1:0] rem_step4(input logic [SIDE_W-1:0] rem,
                                                  input logic [3:0] bits,
                                                  input logic [SIDE_W-1:0] side);
    logic [SIDE_W:0]   acc;
    logic [SIDE_W-1:0] r;
    r = rem;
    for (int i = 3; i >= 0; i--) begin
      acc = {r, bits[i]};
      if (acc >= {1'b0, side}) begin
        acc = acc - {1'b0, side};
      end
      r = acc[SIDE_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/periodic_value_noise_sampler.sv
// ---------------------------------------------------------------------------
// periodic_value_noise_sampler
// Samples 2D periodic value noise from a square lattice with quintic fade.
// ---------------------------------------------------------------------------
// Usage:
//   The in_ channel takes requests. in_tuser selects the kind: a write
//   stores entry_value at entry_index of the lattice, an evaluate gives a
//   point x,y in signed 16.16 fixed point. Each evaluate yields one 16-bit
//   noise value on the out_ channel; writes yield nothing.
//   cfg_wr_en/cfg_wr_data set the lattice side (wrap period, 1 to 64 cells);
//   the user must use them only while no request is in flight; the block does not check this.
// Timing:
//   A 13-stage pipeline accepts one request per cycle while no stall holds
//   it. A result appears on out_tvalid once its request reaches stage 13.
//   Writes reach the lattice in stage 9, in request order with the reads.
// Reset:
//   Reset empties the pipeline and sets the side to 64. Lattice contents are
//   not cleared and must be written before they are sampled.
// Stalls:
//   When out_tready is low the result holds; earlier stages keep moving into
//   empty slots, so in_tready falls only once every stage is occupied.
// ---------------------------------------------------------------------------
`include "periodic_value_noise_sampler_assert.svh"

module periodic_value_noise_sampler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data,   // lattice_side
  input  logic        in_tvalid,
  output logic        in_tready,
  // in_tdata: entry_index[11:0], entry_value[27:12], x_fixed[59:28],
  // y_fixed[91:60], zero pad[95:92]
  input  logic [95:0] in_tdata,
  input  logic [0:0]  in_tuser,      // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata      // noise_value
);

  localparam int N  = pvns_pkg::NUM_STAGES;
  localparam int MS = pvns_pkg::MEM_STAGE;

  logic [pvns_pkg::SIDE_W-1:0] side_r;
  logic [pvns_pkg::SIDE_W-1:0] side_nxt;

  pvns_pkg::stage_t pipe_r   [1:N];
  pvns_pkg::stage_t pipe_nxt [1:N];
  logic [N:1]       vld_r;
  logic [N:1]       en;

  pvns_pkg::lat_wr_t                         lat_wr;
  logic [3:0][pvns_pkg::IDX_W-1:0]           lat_addr;
  logic [3:0][pvns_pkg::VAL_W-1:0]           lat_data;

  // Configured side, clamped to the supported range on write.
  always_comb begin
    side_nxt = cfg_wr_data;
    if (cfg_wr_data == '0) begin
      side_nxt = 7'd1;
    end else if (cfg_wr_data > 7'(pvns_pkg::MAX_SIDE)) begin
      side_nxt = 7'(pvns_pkg::MAX_SIDE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= 7'(pvns_pkg::MAX_SIDE);
    end else if (cfg_wr_en) begin
      side_r <= side_nxt;
    end
  end

  // Stage enables: a stage loads when it is empty or its contents move on.
  // A write leaving the last stage needs no receiver.
  always_comb begin
    en[N] = !(vld_r[N] && pipe_r[N].op == pvns_pkg::OP_EVAL) || out_tready;
    for (int k = N - 1; k >= 1; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign in_tready  = en[1];
  assign out_tvalid = vld_r[N] && pipe_r[N].op == pvns_pkg::OP_EVAL;
  assign out_tdata  = pipe_r[N].noise;

  // Stage 1: split coordinates into cell magnitude and fraction; square t.
  always_comb begin
    logic [31:0] x;
    logic [31:0] y;
    x = in_tdata[59:28];
    y = in_tdata[91:60];
    pipe_nxt[1]      = '0;
    pipe_nxt[1].op   = in_tuser[0];
    pipe_nxt[1].widx = in_tdata[11:0];
    pipe_nxt[1].wval = in_tdata[27:12];
    pipe_nxt[1].xneg = x[31];
    pipe_nxt[1].yneg = y[31];
    pipe_nxt[1].xmag = x[31] ? 16'(~x[31:16] + 16'd1) : x[31:16];
    pipe_nxt[1].ymag = y[31] ? 16'(~y[31:16] + 16'd1) : y[31:16];
    pipe_nxt[1].xf   = x[15:0];
    pipe_nxt[1].yf   = y[15:0];
    pipe_nxt[1].xsq  = 32'(x[15:0]) * 32'(x[15:0]);
    pipe_nxt[1].ysq  = 32'(y[15:0]) * 32'(y[15:0]);
  end

  // Stage 2: first remainder bits; round t^2, form t^3 product and poly.
  always_comb begin
    logic [32:0] sx;
    logic [32:0] sy;
    pipe_nxt[2] = pipe_r[1];
    pipe_nxt[2].xrem = pvns_pkg::rem_step4('0, pipe_r[1].xmag[15:12], side_r);
    pipe_nxt[2].yrem = pvns_pkg::rem_step4('0, pipe_r[1].ymag[15:12], side_r);
    sx = 33'(pipe_r[1].xsq) + 33'(pvns_pkg::HALF);
    sy = 33'(pipe_r[1].ysq) + 33'(pvns_pkg::HALF);
    pipe_nxt[2].xt2   = sx[32:16];
    pipe_nxt[2].yt2   = sy[32:16];
    pipe_nxt[2].xcube = 33'(sx[32:16]) * 33'(pipe_r[1].xf);
    pipe_nxt[2].ycube = 33'(sy[32:16]) * 33'(pipe_r[1].yf);
    // 6t^2 - 15t + 10, always positive for t in [0, 1).
    pipe_nxt[2].xpoly = 21'(22'(sx[32:16]) * 22'd6 + 22'(10 * pvns_pkg::SCALE)
                            - 22'(pipe_r[1].xf) * 22'd15);
    pipe_nxt[2].ypoly = 21'(22'(sy[32:16]) * 22'd6 + 22'(10 * pvns_pkg::SCALE)
                            - 22'(pipe_r[1].yf) * 22'd15);
  end

  // Stage 3: more remainder bits; round t^3 and multiply by the poly.
  always_comb begin
    logic [33:0] cx;
    logic [33:0] cy;
    pipe_nxt[3] = pipe_r[2];
    pipe_nxt[3].xrem = pvns_pkg::rem_step4(pipe_r[2].xrem, pipe_r[2].xmag[11:8], side_r);
    pipe_nxt[3].yrem = pvns_pkg::rem_step4(pipe_r[2].yrem, pipe_r[2].ymag[11:8], side_r);
    cx = 34'(pipe_r[2].xcube) + 34'(pvns_pkg::HALF);
    cy = 34'(pipe_r[2].ycube) + 34'(pvns_pkg::HALF);
    pipe_nxt[3].xt3 = cx[32:16];
    pipe_nxt[3].yt3 = cy[32:16];
    pipe_nxt[3].xfp = 38'(cx[32:16]) * 38'(pipe_r[2].xpoly);
    pipe_nxt[3].yfp = 38'(cy[32:16]) * 38'(pipe_r[2].ypoly);
  end

  // Stage 4: more remainder bits; round the fade and clamp it to one.
  always_comb begin
    logic [38:0] rx;
    logic [38:0] ry;
    pipe_nxt[4] = pipe_r[3];
    pipe_nxt[4].xrem = pvns_pkg::rem_step4(pipe_r[3].xrem, pipe_r[3].xmag[7:4], side_r);
    pipe_nxt[4].yrem = pvns_pkg::rem_step4(pipe_r[3].yrem, pipe_r[3].ymag[7:4], side_r);
    rx = 39'(pipe_r[3].xfp) + 39'(pvns_pkg::HALF);
    ry = 39'(pipe_r[3].yfp) + 39'(pvns_pkg::HALF);
    pipe_nxt[4].fx = (rx[38:16] > 23'(pvns_pkg::SCALE)) ? 17'(pvns_pkg::SCALE)
                                                        : rx[32:16];
    pipe_nxt[4].fy = (ry[38:16] > 23'(pvns_pkg::SCALE)) ? 17'(pvns_pkg::SCALE)
                                                        : ry[32:16];
  end

  // Stage 5: last remainder bits.
  always_comb begin
    pipe_nxt[5] = pipe_r[4];
    pipe_nxt[5].xrem = pvns_pkg::rem_step4(pipe_r[4].xrem, pipe_r[4].xmag[3:0], side_r);
    pipe_nxt[5].yrem = pvns_pkg::rem_step4(pipe_r[4].yrem, pipe_r[4].ymag[3:0], side_r);
  end

  // Stage 6: floor modulo for negative cells.
  always_comb begin
    logic [pvns_pkg::SIDE_W-1:0] dx;
    logic [pvns_pkg::SIDE_W-1:0] dy;
    dx = side_r - pipe_r[5].xrem;
    dy = side_r - pipe_r[5].yrem;
    pipe_nxt[6] = pipe_r[5];
    pipe_nxt[6].wx = (pipe_r[5].xneg && pipe_r[5].xrem != '0) ? dx[5:0] : pipe_r[5].xrem[5:0];
    pipe_nxt[6].wy = (pipe_r[5].yneg && pipe_r[5].yrem != '0) ? dy[5:0] : pipe_r[5].yrem[5:0];
  end

  // Stage 7: successor cells with wrap; base row offset.
  always_comb begin
    logic [pvns_pkg::SIDE_W-1:0] sx;
    logic [pvns_pkg::SIDE_W-1:0] sy;
    logic [12:0]                 prod;
    sx = {1'b0, pipe_r[6].wx} + 7'd1;
    sy = {1'b0, pipe_r[6].wy} + 7'd1;
    prod = 13'(pipe_r[6].wy) * 13'(side_r);
    pipe_nxt[7] = pipe_r[6];
    pipe_nxt[7].wx1  = (sx == side_r) ? '0 : sx[5:0];
    pipe_nxt[7].wy1  = (sy == side_r) ? '0 : sy[5:0];
    pipe_nxt[7].row0 = prod[11:0];
  end

  // Stage 8: four corner addresses.
  always_comb begin
    logic [pvns_pkg::IDX_W-1:0] row1;
    row1 = (pipe_r[7].wy1 == '0) ? '0 : pipe_r[7].row0 + 12'(side_r);
    pipe_nxt[8] = pipe_r[7];
    pipe_nxt[8].idx_a = pipe_r[7].row0 + 12'(pipe_r[7].wx);
    pipe_nxt[8].idx_b = pipe_r[7].row0 + 12'(pipe_r[7].wx1);
    pipe_nxt[8].idx_c = row1 + 12'(pipe_r[7].wx);
    pipe_nxt[8].idx_d = row1 + 12'(pipe_r[7].wx1);
  end

  // Stage 9: lattice access, write or corner reads.
  assign lat_wr.en   = en[MS] && vld_r[MS-1] && pipe_r[MS-1].op == pvns_pkg::OP_WRITE;
  assign lat_wr.addr = pipe_r[MS-1].widx;
  assign lat_wr.data = pipe_r[MS-1].wval;
  assign lat_addr[0] = pipe_r[MS-1].idx_a;
  assign lat_addr[1] = pipe_r[MS-1].idx_b;
  assign lat_addr[2] = pipe_r[MS-1].idx_c;
  assign lat_addr[3] = pipe_r[MS-1].idx_d;

  pvns_lattice_mem u_lattice (
    .clk     (clk),
    .wr      (lat_wr),
    .rd_en   (en[MS]),
    .rd_addr (lat_addr),
    .rd_data (lat_data)
  );

  always_comb begin
    pipe_nxt[9] = pipe_r[8];
  end

  // Stage 10: horizontal differences times the x fade.
  always_comb begin
    logic signed [16:0] dlo;
    logic signed [16:0] dhi;
    dlo = $signed({1'b0, lat_data[1]}) - $signed({1'b0, lat_data[0]});
    dhi = $signed({1'b0, lat_data[3]}) - $signed({1'b0, lat_data[2]});
    pipe_nxt[10] = pipe_r[9];
    pipe_nxt[10].lo_base = lat_data[0];
    pipe_nxt[10].hi_base = lat_data[2];
    pipe_nxt[10].plo = 35'(dlo) * $signed({18'd0, pipe_r[9].fx});
    pipe_nxt[10].phi = 35'(dhi) * $signed({18'd0, pipe_r[9].fx});
  end

  // Stage 11: round and add, giving the lower and upper rows.
  always_comb begin
    logic signed [34:0] rl;
    logic signed [34:0] rh;
    rl = pipe_r[10].plo + 35'sd32768;
    rh = pipe_r[10].phi + 35'sd32768;
    pipe_nxt[11] = pipe_r[10];
    pipe_nxt[11].lo = $signed({2'b00, pipe_r[10].lo_base}) + 18'(rl >>> pvns_pkg::FRAC_W);
    pipe_nxt[11].hi = $signed({2'b00, pipe_r[10].hi_base}) + 18'(rh >>> pvns_pkg::FRAC_W);
  end

  // Stage 12: vertical difference times the y fade.
  always_comb begin
    logic signed [17:0] dv;
    dv = pipe_r[11].hi - pipe_r[11].lo;
    pipe_nxt[12] = pipe_r[11];
    pipe_nxt[12].pv = 36'(dv) * $signed({19'd0, pipe_r[11].fy});
  end

  // Stage 13: round and add, giving the noise value.
  always_comb begin
    logic signed [35:0] rv;
    logic signed [17:0] v;
    rv = pipe_r[12].pv + 36'sd32768;
    v  = pipe_r[12].lo + 18'(rv >>> pvns_pkg::FRAC_W);
    pipe_nxt[13] = pipe_r[12];
    pipe_nxt[13].noise = v[15:0];
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[1]) begin
        vld_r[1] <= in_tvalid;
      end
      for (int k = 2; k <= N; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    for (int k = 1; k <= N; k++) begin
      if (en[k]) begin
        pipe_r[k] <= pipe_nxt[k];
      end
    end
  end

  // Input can only be refused when the whole pipeline is full and stuck.
  `PVNS_ASSERT_IMPL(a_full_when_blocked, !in_tready, (&vld_r) && out_tvalid && !out_tready,
                    "input refused while the pipeline has room")
  // The fade factor never exceeds one.
  `PVNS_ASSERT_IMPL(a_fade_bound, vld_r[5],
                    pipe_r[5].fx <= 17'(pvns_pkg::SCALE) && pipe_r[5].fy <= 17'(pvns_pkg::SCALE),
                    "fade factor out of range")
  // An accepted request occupies the first stage on the next cycle.
  `PVNS_ASSERT_NEXT(a_accept_loads, in_tvalid && in_tready, vld_r[1],
                    "accepted request lost at pipeline entry")

endmodule

// File: hw/rtl/pvns_lattice_mem.sv
// ---------------------------------------------------------------------------
// pvns_lattice_mem
// Lattice store, replicated four times so that all corners of a cell are
// read together. Every write goes to all copies; reads are registered.
// ---------------------------------------------------------------------------
module pvns_lattice_mem (
  input  logic                                         clk,
  input  pvns_pkg::lat_wr_t                            wr,
  input  logic                                         rd_en,
  input  logic [3:0][pvns_pkg::IDX_W-1:0]              rd_addr,
  output logic [3:0][pvns_pkg::VAL_W-1:0]              rd_data
);

  // One copy per corner read port.
  for (genvar g = 0; g < 4; g++) begin : g_copy
    logic [pvns_pkg::VAL_W-1:0] mem [pvns_pkg::DEPTH];
    logic [pvns_pkg::VAL_W-1:0] rdata_r;

    // Write shared by all copies, read on this copy's own port.
    always_ff @(posedge clk) begin
      if (wr.en) begin
        mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
        rdata_r <= mem[rd_addr[g]];
      end
    end

    assign rd_data[g] = rdata_r;
  end

endmodule

// File: bench/tb_periodic_value_noise_sampler.sv
// ----------------------------------------------------------------------------
// Periodic value noise sampler testbench
// Fills the lattice through write requests, evaluates points at several wrap periods
// and compares every noise value against a local fixed-point predictor of the floor,
// wrap, quintic fade and lerp chain. Both sides idle at random except in the last phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_periodic_value_noise_sampler;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int ITEM_TARGET    = 550;

  typedef struct packed {
    logic        op;
    logic [11:0] entry_index;
    logic [15:0] entry_value;
    logic [31:0] x_fixed;
    logic [31:0] y_fixed;
  } request_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [6:0]  cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [95:0] in_tdata;
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;

  // Predictor state. lattice_written marks entries that a queued write covers.
  logic [15:0] lattice_copy [pvns_pkg::DEPTH];
  bit          lattice_written [pvns_pkg::DEPTH];
  int          side_setting;

  request_t    pending_requests [$];
  logic [15:0] expected_noise [$];
  int          queued_count;
  int          mismatch_count;
  int          noise_checked;
  int          quiet_cycles;
  bit          idle_free;
  int          in_gap;
  int          out_gap;

  periodic_value_noise_sampler u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Clock.
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Fixed multiply with floor division by the scale and round half up.
  function automatic longint mul_round_half_up(longint a, longint b);
    longint p;
    longint q;
    p = a * b;
    q = p >>> pvns_pkg::FRAC_W;
    return ((p - q * pvns_pkg::SCALE) >= pvns_pkg::HALF) ? q + 1 : q;
  endfunction

  function automatic longint quintic_fade(longint t);
    longint t2;
    longint t3;
    longint r;
    t2 = mul_round_half_up(t, t);
    t3 = mul_round_half_up(t2, t);
    r = mul_round_half_up(t3, 6 * t2 - 15 * t + 10 * longint'(pvns_pkg::SCALE));
    if (r < 0) r = 0;
    if (r > pvns_pkg::SCALE) r = pvns_pkg::SCALE;
    return r;
  endfunction

  function automatic longint wrap_cell(longint c, longint s);
    longint r;
    r = c % s;
    return (r < 0) ? r + s : r;
  endfunction

  function automatic longint lattice_at(longint s, longint cx, longint cy);
    return longint'(lattice_copy[wrap_cell(cy, s) * s + wrap_cell(cx, s)]);
  endfunction

  function automatic longint side_in_use();
    longint s;
    s = side_setting;
    if (s < 1) s = 1;
    if (s > pvns_pkg::MAX_SIDE) s = pvns_pkg::MAX_SIDE;
    return s;
  endfunction

  function automatic logic [15:0] predict_noise(logic [31:0] xr, logic [31:0] yr);
    longint s;
    longint x;
    longint y;
    longint xc;
    longint yc;
    longint fx;
    longint fy;
    longint a;
    longint b;
    longint lo;
    longint hi;
    s = side_in_use();
    x = longint'(signed'(xr));
    y = longint'(signed'(yr));
    xc = x >>> pvns_pkg::FRAC_W;
    yc = y >>> pvns_pkg::FRAC_W;
    fx = quintic_fade(x - xc * pvns_pkg::SCALE);
    fy = quintic_fade(y - yc * pvns_pkg::SCALE);
    a = lattice_at(s, xc, yc);
    b = lattice_at(s, xc + 1, yc);
    lo = a + mul_round_half_up(b - a, fx);
    a = lattice_at(s, xc, yc + 1);
    b = lattice_at(s, xc + 1, yc + 1);
    hi = a + mul_round_half_up(b - a, fx);
    return 16'(lo + mul_round_half_up(hi - lo, fy));
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // Queue helpers for the stimulus.
  task automatic enqueue_request(input request_t r);
    pending_requests = {pending_requests, r};
    queued_count++;
  endtask

  task automatic add_write(input int idx, input logic [15:0] val);
    request_t r;
    r = '0;
    r.op = pvns_pkg::OP_WRITE;
    r.entry_index = 12'(idx);
    r.entry_value = val;
    if (idx >= 0 && idx < pvns_pkg::DEPTH) lattice_written[idx] = 1'b1;
    enqueue_request(r);
  endtask

  // Writes every corner of the point's cell that no earlier request covers.
  task automatic cover_corners(input logic [31:0] x, input logic [31:0] y);
    longint s;
    longint xc;
    longint yc;
    longint idx;
    s  = side_in_use();
    xc = longint'(signed'(x)) >>> pvns_pkg::FRAC_W;
    yc = longint'(signed'(y)) >>> pvns_pkg::FRAC_W;
    for (int dy = 0; dy < 2; dy++) begin
      for (int dx = 0; dx < 2; dx++) begin
        idx = wrap_cell(yc + dy, s) * s + wrap_cell(xc + dx, s);
        if (!lattice_written[idx]) add_write(int'(idx), 16'($urandom));
      end
    end
  endtask

  task automatic add_eval(input logic [31:0] x, input logic [31:0] y);
    request_t r;
    cover_corners(x, y);
    r = '0;
    r.op = pvns_pkg::OP_EVAL;
    r.x_fixed = x;
    r.y_fixed = y;
    r.entry_index = 12'($urandom);
    r.entry_value = 16'($urandom);
    enqueue_request(r);
  endtask

  function automatic logic [31:0] random_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'(int'($urandom_range(0, 2 * 64 * pvns_pkg::SCALE)) - 64 * pvns_pkg::SCALE);
      2: return {16'($urandom_range(0, 3) - 2), 16'($urandom)};
      default: return {16'($urandom_range(0, 200)),
                       16'(pvns_pkg::HALF + $urandom_range(0, 2) - 1)};
    endcase
  endfunction

  // Waits until the queue is sent and every noise value has returned.
  task automatic wait_drained();
    while (pending_requests.size() != 0 || expected_noise.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_side(input int s);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= 7'(s);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    side_setting = s;
  endtask

  // Request driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap    <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        if (in_tuser[0] == pvns_pkg::OP_WRITE) begin
          if (in_tdata[11:0] < pvns_pkg::DEPTH) begin
            lattice_copy[in_tdata[11:0]] = in_tdata[27:12];
          end
        end else begin
          expected_noise = {expected_noise, predict_noise(in_tdata[59:28], in_tdata[91:60])};
        end
        void'(pending_requests.pop_front());
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap    <= in_gap - 1;
          in_tvalid <= 1'b0;
        end else if (!idle_free && $urandom_range(0, 7) == 0) begin
          in_gap    <= $urandom_range(0, 2);
          in_tvalid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          in_tvalid <= 1'b1;
          in_tuser  <= pending_requests[0].op;
          in_tdata  <= {4'b0, pending_requests[0].y_fixed, pending_requests[0].x_fixed,
                        pending_requests[0].entry_value, pending_requests[0].entry_index};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and stall generator.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready   <= 1'b0;
      out_gap      <= 0;
      quiet_cycles <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_noise.size() == 0) begin
          report_mismatch("unexpected noise value", out_tdata, 16'h0);
        end else begin
          if (out_tdata !== expected_noise[0])
            report_mismatch("noise_value", out_tdata, expected_noise[0]);
          void'(expected_noise.pop_front());
        end
        noise_checked++;
      end
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready)
          || (pending_requests.size() == 0 && expected_noise.size() == 0))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (out_gap > 0) begin
        out_gap    <= out_gap - 1;
        out_tready <= 1'b0;
      end else if (!idle_free && $urandom_range(0, 6) == 0) begin
        out_gap    <= $urandom_range(0, 2);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin
    int sides [6];
    int phase_end;
    int s;
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = '0;
    out_tready     = 1'b0;
    queued_count   = 0;
    mismatch_count = 0;
    noise_checked  = 0;
    idle_free      = 1'b0;
    side_setting   = pvns_pkg::MAX_SIDE;
    foreach (lattice_copy[i]) lattice_copy[i] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at a small side: extremes of values and coordinates.
    set_side(2);
    add_write(0, 16'h0000);
    add_write(1, 16'hFFFF);
    add_write(2, 16'hFFFF);
    add_write(3, 16'h0000);
    add_write(4095, 16'hA5A5);
    add_eval(32'h0000_0000, 32'h0000_0000);
    add_eval(32'h0000_8000, 32'h0000_8000);
    add_eval(32'h0000_FFFF, 32'h0000_FFFF);
    add_eval(32'h7FFF_FFFF, 32'h8000_0000);
    add_eval(32'h8000_0000, 32'h7FFF_FFFF);
    add_eval(32'hFFFF_FFFF, 32'hFFFF_0001);
    add_eval(32'h0001_7FFF, 32'hFFFE_8001);
    wait_drained();

    // Side zero behaves as side one; the value above the max saturates.
    set_side(0);
    add_write(0, 16'h1234);
    add_eval(32'h0003_4000, 32'hFFF0_C000);
    add_eval(32'hFFFF_FFFF, 32'h7FFF_FFFF);
    wait_drained();
    set_side(127);
    add_eval(32'h003F_FFFF, 32'h0040_0000);
    add_eval(32'hFFC0_8000, 32'h0000_0001);
    wait_drained();

    // Random phases across a spread of sides, extremes included.
    sides = '{1, 64, 3, 37, 100, 7};
    for (int p = 0; p < 6; p++) begin
      set_side(sides[p]);
      phase_end = queued_count + (ITEM_TARGET - queued_count) / (6 - p);
      if (p == 5) idle_free = 1'b1;
      while (queued_count < phase_end) begin
        if ($urandom_range(0, 4) == 0) begin
          s = int'(side_in_use());
          if ($urandom_range(0, 9) == 0)
            add_write(pvns_pkg::DEPTH - 1 - int'($urandom_range(0, 15)), 16'($urandom));
          else add_write(int'($urandom_range(0, s * s - 1)), 16'($urandom));
        end else begin
          add_eval(random_coord(), random_coord());
        end
      end
      wait_drained();
    end

    $display("Sent %0d requests and checked %0d noise values over lattice sides 0 to 127,",
             queued_count, noise_checked);
    $display("with random idling on both channels except in the closing phase.");
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
